[src/xtea_pkg.sv]
// Shared types, register codes and the round mixing function for the XTEA cipher.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package xtea_pkg;

  typedef logic [31:0] word_t;
  typedef logic [63:0] block_t;

  localparam word_t DELTA = 32'h9E37_79B9;

  // Configuration register indexes, in write-port order.
  typedef enum logic [2:0] {
    REG_KEY_0 = 3'd0,
    REG_KEY_1 = 3'd1,
    REG_KEY_2 = 3'd2,
    REG_KEY_3 = 3'd3,
    REG_MODE  = 3'd4
  } cfg_reg_t;

  // Control that every pipeline stage sees.
  typedef struct packed {
    logic advance;
    logic decrypt;
  } stage_ctrl_t;

  function automatic word_t mix_word(input word_t w);
    mix_word = ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

`default_nettype wire

[src/xtea_block_cipher.sv]
// XTEA block cipher, one 64-bit block per transaction, 2*ROUNDS half-round stages.
// A block passes through the 2*ROUNDS stage registers in order, the last of which drives the result.
// Throughput is one block per cycle; a stalled result freezes the pipeline.
// Reset clears all stage valid bits, the key words and the mode (encrypt).
// Depends on xtea_pkg, xtea_cfg and xtea_stage.
`default_nettype none

module xtea_block_cipher #(
  parameter int ROUNDS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         data_valid,
  output logic              data_stall,
  input  wire logic [63:0]  data_block,
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic [63:0]       result_block
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::word_t [3:0]   keys;
  logic                    decrypt;
  logic                    advance;
  xtea_pkg::stage_ctrl_t   ctrl;
  logic [STAGES:0]         valid_vec;
  xtea_pkg::block_t        block_vec [STAGES+1];

  xtea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys),
    .decrypt   (decrypt)
  );

  // The last stage register doubles as the output register.
  assign advance      = !(result_valid && result_stall);
  assign data_stall   = !advance;
  assign ctrl.advance = advance;
  assign ctrl.decrypt = decrypt;

  assign valid_vec[0]  = data_valid;
  assign block_vec[0]  = data_block;
  assign result_valid  = valid_vec[STAGES];
  assign result_block  = block_vec[STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    // Stage k belongs to round k/2; odd stages use the stepped sum.
    localparam int unsigned ENC_MULT = k / 2 + k % 2;
    localparam int unsigned DEC_MULT = ROUNDS - k / 2 - k % 2;
    localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(xtea_pkg::DELTA);
    localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(xtea_pkg::DELTA);
    localparam xtea_pkg::word_t ENC_SUM = ENC_PROD[31:0];
    localparam xtea_pkg::word_t DEC_SUM = DEC_PROD[31:0];
    localparam logic ODD = (k % 2) == 1;

    xtea_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .odd       (ODD),
      .enc_sum   (ENC_SUM),
      .dec_sum   (DEC_SUM),
      .keys      (keys),
      .in_valid  (valid_vec[k]),
      .in_block  (block_vec[k]),
      .out_valid (valid_vec[k+1]),
      .out_block (block_vec[k+1])
    );
  end

  // A reset cycle leaves no result behind.
  a_reset_clears : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A frozen pipeline keeps every valid bit in place.
  a_freeze_holds : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(valid_vec[STAGES:1]))
    else $error("stage valid changed while the pipeline was stalled");

  // An accepted transaction enters the first stage.
  a_first_stage : assert property (@(posedge clk) disable iff (rst)
    (advance && data_valid) |=> valid_vec[1])
    else $error("accepted block did not enter the first stage");

  // At the output stage, valid bits move exactly one stage per advancing cycle, none lost or made up.
  a_last_stage : assert property (@(posedge clk) disable iff (rst)
    advance |=> (valid_vec[STAGES] == $past(valid_vec[STAGES-1])))
    else $error("valid bit lost or created at the output stage");

endmodule

`default_nettype wire

[src/xtea_cfg.sv]
// Configuration registers of the XTEA cipher: four key words and the direction.
// Depends on xtea_pkg for the register codes and word type.
`default_nettype none

module xtea_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  output xtea_pkg::word_t [3:0]     keys,
  output logic                      decrypt
);

  always_ff @(posedge clk) begin
    if (rst) begin
      keys    <= '0;
      decrypt <= 1'b0;
    end else if (cfg_we) begin
      case (xtea_pkg::cfg_reg_t'(cfg_index))
        xtea_pkg::REG_KEY_0: keys[0] <= cfg_data;
        xtea_pkg::REG_KEY_1: keys[1] <= cfg_data;
        xtea_pkg::REG_KEY_2: keys[2] <= cfg_data;
        xtea_pkg::REG_KEY_3: keys[3] <= cfg_data;
        xtea_pkg::REG_MODE:  decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/xtea_stage.sv]
// One XTEA half-round as a pipeline stage, with its round key taken from the live key words.
// Depends on xtea_pkg for the mixing function, word types and stage control.
`default_nettype none

module xtea_stage (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire xtea_pkg::stage_ctrl_t  ctrl,
  input  wire logic                   odd,
  input  wire xtea_pkg::word_t        enc_sum,
  input  wire xtea_pkg::word_t        dec_sum,
  input  wire xtea_pkg::word_t [3:0]  keys,
  input  wire logic                   in_valid,
  input  wire xtea_pkg::block_t       in_block,
  output logic                        out_valid,
  output xtea_pkg::block_t            out_block
);

  logic             upd_left;
  xtea_pkg::word_t  sel_sum;
  logic [1:0]       key_idx;
  xtea_pkg::word_t  rk;
  xtea_pkg::word_t  left;
  xtea_pkg::word_t  right;
  xtea_pkg::word_t  src;
  xtea_pkg::word_t  dst;
  xtea_pkg::word_t  f;
  xtea_pkg::word_t  upd;
  xtea_pkg::block_t out_block_next;

  // Encryption updates the left word on even stages, decryption on odd ones.
  // A left-word update always keys on sum[1:0], a right-word update on sum[12:11].
  // The round key add runs in parallel with the mixing of the source word.
  always_comb begin
    upd_left = ctrl.decrypt ? odd : !odd;
    sel_sum  = ctrl.decrypt ? dec_sum : enc_sum;
    key_idx  = upd_left ? sel_sum[1:0] : sel_sum[12:11];
    rk       = sel_sum + keys[key_idx];
  end

  always_comb begin
    left  = in_block[31:0];
    right = in_block[63:32];
    src   = upd_left ? right : left;
    dst   = upd_left ? left : right;
    f     = xtea_pkg::mix_word(src) ^ rk;
    upd   = ctrl.decrypt ? (dst - f) : (dst + f);
    out_block_next = upd_left ? {right, upd} : {upd, left};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      out_block <= out_block_next;
    end
  end

endmodule

`default_nettype wire
